// ===== design/gbd_pkg.sv =====
// Shared package of the grid border dilation block.
// Holds the cell codes, register indexes, stream widths and the types passed
// between the window, coordinate and result modules. No dependencies.
`timescale 1ns / 1ps

package gbd_pkg;

  // Default limits of the map geometry.
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field widths.
  localparam int CELL_W      = 3;
  localparam int CFG_W       = 9;
  localparam int COORD_W     = 8;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 24;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  typedef logic [CELL_W-1:0] cell_t;

  // Cell codes.
  localparam cell_t CELL_EMPTY  = 3'd0;
  localparam cell_t CELL_TRACK  = 3'd1;
  localparam cell_t CELL_BORDER = 3'd2;
  localparam cell_t CELL_START  = 3'd3;
  localparam cell_t CELL_FINISH = 3'd4;

  // Input command codes.
  localparam logic CMD_CELL  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes, taken from address bit 2.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // The 3x3 window: entry row*3 + k. Row 0 holds the newest row (below the
  // centre), row 2 the oldest (above). Offset k = 0 is the right-hand column.
  typedef logic [8:0][CELL_W-1:0] win_t;

  // Position data of the cell in the window centre.
  typedef struct packed {
    logic               last;
    logic [2:0]         row_ok;  // neighbour row is interior: [0] above .. [2] below
    logic [2:0]         col_ok;  // neighbour column is interior: [0] left .. [2] right
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } meta_t;

  function automatic logic is_active(cell_t c);
    return (c == CELL_TRACK) || (c == CELL_START) || (c == CELL_FINISH);
  endfunction

endpackage

// ===== design/grid_border_dilation.sv =====
// Top level of the grid border dilation block: stream ports, APB geometry
// registers and the connection of window, position and result modules.
// Depends on gbd_pkg, gbd_cfg, gbd_coord, gbd_window and gbd_result.
`timescale 1ns / 1ps

// Map cells enter in raster order on the slave stream, one transaction per
// clock while s_axis_tready is high, and each cell leaves grid_width + 1
// input transactions later with empty cells next to an active interior cell
// marked as border, start cells turned into track with tuser set, and tlast
// on the last cell of the map. Flush transactions count as empty cells and
// push out the final row. Once a cell's last neighbour is accepted, its
// position is registered as pending, then the cell moves to the output
// register. One result may wait in the output register and a second one
// behind it without holding up the input; once both are held and the
// receiver stalls, s_axis_tready drops until the output register is read.
// The history lives in one memory of 2**ceil(log2(2*MAX_WIDTH+3)) entries
// with one write and two read ports; these two read ports set the rate.
// After every geometry register write the window taps are reloaded from
// that memory, during which s_axis_tready is low. No clearing pass is needed
// after reset: a fill count makes unwritten history read as empty.

module grid_border_dilation import gbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Slave stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [2:0] cell_in, rest zero
  input  logic                   s_axis_tuser,   // [0] cmd
  // Master stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [2:0] cell_out, [10:3] out_col,
                                                 // [18:11] out_row, rest zero
  output logic                   m_axis_tuser,   // [0] is_start
  output logic                   m_axis_tlast,   // frame_last
  // Configuration.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic          cfg_wr, accept, emit, busy, free;
  logic [WW-1:0] width;
  logic [HW-1:0] height;
  cell_t         cell_in;
  win_t          win;
  meta_t         meta;

  assign pready = 1'b1;

  // A transaction is taken when the result stage holds no pending cell or can
  // hand it on, and the window taps are not being reloaded.
  assign s_axis_tready = free && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // A flush enters the history as an empty cell.
  assign cell_in = (s_axis_tuser == CMD_FLUSH) ? CELL_EMPTY : s_axis_tdata[CELL_W-1:0];

  gbd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cfg_wr_o (cfg_wr),
    .width_o  (width),
    .height_o (height)
  );

  gbd_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .clear_i  (cfg_wr),
    .width_i  (width),
    .height_i (height),
    .emit_o   (emit),
    .meta_o   (meta)
  );

  gbd_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cell_i   (cell_in),
    .cfg_wr_i (cfg_wr),
    .width_i  (width),
    .busy_o   (busy),
    .win_o    (win)
  );

  gbd_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .emit_i     (emit),
    .win_i      (win),
    .meta_i     (meta),
    .free_o     (free),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== design/gbd_cfg.sv =====
// Geometry registers of the grid border dilation block behind an APB port.
// Also clamps the geometry to the supported range. Depends on gbd_pkg.
`timescale 1ns / 1ps

module gbd_cfg import gbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  cfg_wr_o,
  output logic [WW-1:0]         width_o,
  output logic [HW-1:0]         height_o
);

  localparam int DWW = (CFG_W > WW) ? CFG_W : WW;
  localparam int DHW = (CFG_W > HW) ? CFG_W : HW;

  logic [CFG_W-1:0] width_q, height_q;
  logic [DWW-1:0]   wraw, wcl;
  logic [DHW-1:0]   hraw, hcl;

  assign cfg_wr_o = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(256);
      height_q <= CFG_W'(256);
    end else if (cfg_wr_o) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  assign wraw = DWW'(width_q);
  assign hraw = DHW'(height_q);

  always_comb begin
    if (wraw == '0) begin
      wcl = DWW'(1);
    end else if (wraw > DWW'(MAX_WIDTH)) begin
      wcl = DWW'(MAX_WIDTH);
    end else begin
      wcl = wraw;
    end
    if (hraw == '0) begin
      hcl = DHW'(1);
    end else if (hraw > DHW'(MAX_HEIGHT)) begin
      hcl = DHW'(MAX_HEIGHT);
    end else begin
      hcl = hraw;
    end
  end

  assign width_o  = WW'(wcl);
  assign height_o = HW'(hcl);

endmodule

// ===== design/gbd_coord.sv =====
// Position counters of the grid border dilation block: tracks the incoming
// row and column and derives the centre cell's position and interior flags.
// Depends on gbd_pkg.
`timescale 1ns / 1ps

module gbd_coord import gbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          clear_i,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  output logic          emit_o,
  output meta_t         meta_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int XW = $clog2(MAX_WIDTH + 4);
  localparam int YW = $clog2(MAX_HEIGHT + 4);

  logic [CW-1:0]      col_q;
  logic [RW-1:0]      row_q;
  meta_t              meta_q;
  logic [XW-1:0]      wx, colx, cc, colp;
  logic [YW-1:0]      hy, rowy, cr;
  logic               last;
  logic [XW+7:0]      cc_ext;
  logic [YW+7:0]      cr_ext;
  meta_t              meta_d;

  assign wx   = XW'(width_i);
  assign hy   = YW'(height_i);
  assign colx = XW'(col_q);
  assign rowy = YW'(row_q);
  assign colp = colx + XW'(1);

  // The centre lies one row and one column behind the incoming cell.
  always_comb begin
    if (colx != '0) begin
      emit_o = (rowy != '0);
      cr     = rowy - YW'(1);
      cc     = colx - XW'(1);
    end else begin
      emit_o = (rowy >= YW'(2));
      cr     = rowy - YW'(2);
      cc     = wx - XW'(1);
    end
  end

  assign last   = emit_o && (cr + YW'(1) == hy) && (cc + XW'(1) == wx);
  assign cc_ext = {8'd0, cc};
  assign cr_ext = {8'd0, cr};

  always_comb begin
    meta_d.last      = last;
    meta_d.col_ok[0] = (cc >= XW'(2)) && (cc + XW'(1) <= wx);
    meta_d.col_ok[1] = (cc >= XW'(1)) && (cc + XW'(2) <= wx);
    meta_d.col_ok[2] = (cc + XW'(3) <= wx);
    meta_d.row_ok[0] = (cr >= YW'(2)) && (cr + YW'(1) <= hy);
    meta_d.row_ok[1] = (cr >= YW'(1)) && (cr + YW'(2) <= hy);
    meta_d.row_ok[2] = (cr + YW'(3) <= hy);
    meta_d.col       = cc_ext[COORD_W-1:0];
    meta_d.row       = cr_ext[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (clear_i || (accept_i && last)) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      if (colp >= wx) begin
        col_q <= '0;
        row_q <= row_q + RW'(1);
      end else begin
        col_q <= CW'(colp);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      meta_q <= meta_d;
    end
  end

  assign meta_o = meta_q;

endmodule

// ===== design/gbd_window.sv =====
// Cell history of the grid border dilation block: a two-row line memory with
// two read ports and the 3x3 window registers fed from it. Depends on gbd_pkg.
`timescale 1ns / 1ps

module gbd_window import gbd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  cell_t         cell_i,
  input  logic          cfg_wr_i,
  input  logic [WW-1:0] width_i,
  output logic          busy_o,
  output win_t          win_o
);

  localparam int D  = 2 ** $clog2(2 * MAX_WIDTH + 3);
  localparam int AW = $clog2(D);
  localparam int NW = $clog2(D + 2);

  cell_t          hist_mem [D];
  logic [AW-1:0]  wp_q, base, addr_a, addr_b;
  logic [NW-1:0]  cnt_q, cnt_eff, age_a, age_b;
  logic [1:0]     rf_q, off;
  logic           refreshing, step;
  cell_t          rd_a_q, rd_b_q, mid_a, mid_b;
  logic           ok_a_q, ok_b_q;
  cell_t          near0_q, near1_q, near2_q;
  cell_t          mid1_q, mid2_q, far1_q, far2_q;

  // After a width change the four delayed taps are stale; they are reloaded
  // by reading ages w+2, w+1 and w (and the same in the older row) in turn.
  assign refreshing = (rf_q != 2'd0);
  assign step       = accept_i || refreshing;
  assign off        = refreshing ? (rf_q - 2'd1) : 2'd0;
  assign busy_o     = refreshing;

  assign age_a   = NW'(width_i) + NW'(off);
  assign age_b   = NW'(width_i) + NW'(width_i) + NW'(off);
  assign base    = accept_i ? wp_q : (wp_q - AW'(1));
  assign addr_a  = base - AW'(age_a);
  assign addr_b  = base - AW'(age_b);
  assign cnt_eff = accept_i ? (cnt_q + NW'(1)) : cnt_q;

  // Entries never written since reset read as empty.
  assign mid_a = ok_a_q ? rd_a_q : CELL_EMPTY;
  assign mid_b = ok_b_q ? rd_b_q : CELL_EMPTY;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hist_mem[wp_q] <= cell_i;
    end
    if (step) begin
      rd_a_q <= hist_mem[addr_a];
      rd_b_q <= hist_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q    <= 2'd0;
      wp_q    <= '0;
      cnt_q   <= '0;
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
      near0_q <= CELL_EMPTY;
      near1_q <= CELL_EMPTY;
      near2_q <= CELL_EMPTY;
      mid1_q  <= CELL_EMPTY;
      mid2_q  <= CELL_EMPTY;
      far1_q  <= CELL_EMPTY;
      far2_q  <= CELL_EMPTY;
    end else begin
      if (cfg_wr_i) begin
        rf_q <= 2'd3;
      end else if (refreshing) begin
        rf_q <= rf_q - 2'd1;
      end
      if (step) begin
        ok_a_q <= (age_a < cnt_eff);
        ok_b_q <= (age_b < cnt_eff);
        mid1_q <= mid_a;
        mid2_q <= mid1_q;
        far1_q <= mid_b;
        far2_q <= far1_q;
      end
      if (accept_i) begin
        near0_q <= cell_i;
        near1_q <= near0_q;
        near2_q <= near1_q;
        wp_q    <= wp_q + AW'(1);
        if (cnt_q != NW'(D)) begin
          cnt_q <= cnt_q + NW'(1);
        end
      end
    end
  end

  assign win_o[0] = near0_q;
  assign win_o[1] = near1_q;
  assign win_o[2] = near2_q;
  assign win_o[3] = mid_a;
  assign win_o[4] = mid1_q;
  assign win_o[5] = mid2_q;
  assign win_o[6] = mid_b;
  assign win_o[7] = far1_q;
  assign win_o[8] = far2_q;

endmodule

// ===== design/gbd_result.sv =====
// Result stage of the grid border dilation block: classifies the window
// centre and holds the outgoing transaction in a register. Depends on gbd_pkg.
`timescale 1ns / 1ps

module gbd_result import gbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   emit_i,
  input  win_t                   win_i,
  input  meta_t                  meta_i,
  output logic                   free_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic [TDATA_OUT_W-1:0] m_tdata_o,
  output logic                   m_tuser_o,
  output logic                   m_tlast_o
);

  logic                   pend_q, out_valid_q, load;
  logic                   near, start;
  cell_t                  centre, res;
  logic [TDATA_OUT_W-1:0] data_q;
  logic                   user_q, last_q;

  assign load   = pend_q && (!out_valid_q || m_tready_i);
  assign free_o = !pend_q || load;
  assign centre = win_i[4];

  always_comb begin
    near = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (!(r == 1 && k == 1) && is_active(win_i[r*3+k]) &&
            meta_i.row_ok[2-r] && meta_i.col_ok[2-k]) begin
          near = 1'b1;
        end
      end
    end
  end

  always_comb begin
    start = 1'b0;
    case (centre)
      CELL_START: begin
        res   = CELL_TRACK;
        start = 1'b1;
      end
      CELL_EMPTY: res = near ? CELL_BORDER : CELL_EMPTY;
      default:    res = centre;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        pend_q <= emit_i;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {5'd0, meta_i.row, meta_i.col, res};
      user_q <= start;
      last_q <= meta_i.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

endmodule
